FILE: rtl/lfps_pkg.sv
// Shared widths, register codes and reset values for the line-follow PID steering block.
package lfps_pkg;

  // Sample, error-sum and gain widths.
  localparam int SAMPLE_BITS = 10;
  localparam int SUM_BITS    = 23;
  localparam int GAIN_BITS   = 16;

  // Error is target minus sample; difference is error minus previous error.
  localparam int ERR_BITS  = SAMPLE_BITS + 1;
  localparam int DIFF_BITS = SAMPLE_BITS + 2;

  // Q8.8 gains are lifted to Q20 by this shift; Q20 has this many fraction bits.
  localparam int GAIN_SHIFT = 12;
  localparam int Q_BITS     = 20;

  // Product widths: unsigned gain widened by one sign bit, times a signed operand.
  localparam int PK_BITS = GAIN_BITS + 1 + ERR_BITS;
  localparam int PD_BITS = GAIN_BITS + 1 + DIFF_BITS;
  localparam int PI_BITS = GAIN_BITS + 1 + SUM_BITS;

  // Accumulator holds the sum of three terms; two spare bits cover the carries.
  localparam int ACC_TERM = (PD_BITS + GAIN_SHIFT > PI_BITS) ? (PD_BITS + GAIN_SHIFT) : PI_BITS;
  localparam int ACC_BITS = ACC_TERM + 2;
  localparam int CMD_BITS = ACC_BITS - Q_BITS;

  // Result format.
  localparam int STEER_BITS  = 8;
  localparam int STEER_LIMIT = 100;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = (SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_TARGET = 2'd0,
    CFG_KP     = 2'd1,
    CFG_KI     = 2'd2,
    CFG_KD     = 2'd3
  } cfg_index_t;

  // Register values after reset.
  localparam logic [SAMPLE_BITS-1:0] TARGET_RESET = SAMPLE_BITS'(550);
  localparam logic [GAIN_BITS-1:0]   KP_RESET     = GAIN_BITS'(448);
  localparam logic [GAIN_BITS-1:0]   KI_RESET     = GAIN_BITS'(1091);
  localparam logic [GAIN_BITS-1:0]   KD_RESET     = GAIN_BITS'(7680);

endpackage

FILE: rtl/line_follow_pid_steering.sv
// Top level of the line-follow PID steering block: error, sum, three products, clamp.
//
//   channel   direction  handshake               payload
//   sample    in         sample_valid/stall      light_sample
//   steer     out        steer_valid/stall       steer_command, clamped
//   cfg       in         cfg_write               cfg_index, cfg_data
//
// One item enters per clock cycle when the result side is not blocked. The
// edge that accepts an item loads the input register with its error,
// difference and updated error sum. Once the result side is free, the
// result register is loaded from the input register through one pass of the
// three gain multiplies, the Q20 add and the truncate-and-clamp logic, and
// the result is offered from the result register until it leaves.
// Reset (synchronous, active high) empties both registers, clears the previous
// error and the error sum, and loads the default gains and target level.
// While a result waits under stall, the input register still takes one more
// item; after that the input stalls until the result side moves again.
module line_follow_pid_steering (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [lfps_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [lfps_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  logic [lfps_pkg::SAMPLE_BITS-1:0]       light_sample,
  output logic                                   steer_valid,
  input  logic                                   steer_stall,
  output logic signed [lfps_pkg::STEER_BITS-1:0] steer_command,
  output logic                                   clamped
);

  localparam int SAMPLE_BITS = lfps_pkg::SAMPLE_BITS;
  localparam int SUM_BITS    = lfps_pkg::SUM_BITS;
  localparam int GAIN_BITS   = lfps_pkg::GAIN_BITS;
  localparam int ERR_BITS    = lfps_pkg::ERR_BITS;
  localparam int DIFF_BITS   = lfps_pkg::DIFF_BITS;
  localparam int PK_BITS     = lfps_pkg::PK_BITS;
  localparam int PD_BITS     = lfps_pkg::PD_BITS;
  localparam int PI_BITS     = lfps_pkg::PI_BITS;
  localparam int ACC_BITS    = lfps_pkg::ACC_BITS;
  localparam int CMD_BITS    = lfps_pkg::CMD_BITS;
  localparam int Q_BITS      = lfps_pkg::Q_BITS;
  localparam int STEER_BITS  = lfps_pkg::STEER_BITS;

  localparam logic signed [CMD_BITS-1:0] LIMIT_POS = CMD_BITS'(lfps_pkg::STEER_LIMIT);
  localparam logic signed [CMD_BITS-1:0] LIMIT_NEG = -LIMIT_POS;

  // Configuration registers. The user must write only while nothing is in flight; the block does not enforce this.
  logic [SAMPLE_BITS-1:0] target_level;
  logic [GAIN_BITS-1:0]   kp_q8;
  logic [GAIN_BITS-1:0]   ki_dt_q20;
  logic [GAIN_BITS-1:0]   kd_rate_q8;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= lfps_pkg::TARGET_RESET;
      kp_q8        <= lfps_pkg::KP_RESET;
      ki_dt_q20    <= lfps_pkg::KI_RESET;
      kd_rate_q8   <= lfps_pkg::KD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lfps_pkg::CFG_TARGET: target_level <= cfg_data[SAMPLE_BITS-1:0];
        lfps_pkg::CFG_KP:     kp_q8        <= cfg_data[GAIN_BITS-1:0];
        lfps_pkg::CFG_KI:     ki_dt_q20    <= cfg_data[GAIN_BITS-1:0];
        lfps_pkg::CFG_KD:     kd_rate_q8   <= cfg_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register occupancy and the ready chain, output end first.
  logic s1_valid;
  logic out_ready, s1_ready;
  logic sample_accept;

  assign out_ready     = !steer_valid || !steer_stall;
  assign s1_ready      = !s1_valid || out_ready;
  assign sample_stall  = !s1_ready;
  assign sample_accept = sample_valid && s1_ready;

  // Input register: error, difference and the saturating error sum. The
  // controller state is updated here, on acceptance, so the next item sees it
  // at once.
  logic signed [ERR_BITS-1:0]  previous_error;
  logic signed [SUM_BITS-1:0]  error_sum;
  logic signed [ERR_BITS-1:0]  err_next;
  logic signed [DIFF_BITS-1:0] diff_next;
  logic signed [SUM_BITS:0]    sum_wide;
  logic signed [SUM_BITS-1:0]  sum_next;

  always_comb begin
    err_next  = $signed({1'b0, target_level}) - $signed({1'b0, light_sample});
    diff_next = DIFF_BITS'(err_next) - DIFF_BITS'(previous_error);
    sum_wide  = (SUM_BITS + 1)'(error_sum) + (SUM_BITS + 1)'(err_next);
    // The top two bits disagree only when the sum has left the signed range.
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      sum_next = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS - 1){1'b0}}}
                                    : {1'b0, {(SUM_BITS - 1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_BITS-1:0];
    end
  end

  logic signed [ERR_BITS-1:0]  s1_err;
  logic signed [DIFF_BITS-1:0] s1_diff;
  logic signed [SUM_BITS-1:0]  s1_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_sum      <= '0;
      s1_valid       <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= sample_valid;
      end
      if (sample_accept) begin
        previous_error <= err_next;
        error_sum      <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_accept) begin
      s1_err  <= err_next;
      s1_diff <= diff_next;
      s1_sum  <= sum_next;
    end
  end

  // Result path, one pass from the input register to the result register.
  // The three gain products are independent; the Q8.8 terms are shifted up
  // to Q20 before the add. The command is the negated accumulator truncated
  // toward zero, which equals the negation of the accumulator truncated
  // toward zero. A negative accumulator gets a bias of one LSB short of a
  // whole unit before the shift so that the arithmetic shift rounds toward
  // zero. The clamp is tested on the unnegated value, so its limits swap sides.
  logic signed [PK_BITS-1:0]    pk_term;
  logic signed [PD_BITS-1:0]    pd_term;
  logic signed [PI_BITS-1:0]    pi_term;
  logic signed [ACC_BITS-1:0]   acc_sum;
  logic signed [ACC_BITS-1:0]   acc_biased;
  logic signed [CMD_BITS-1:0]   acc_trunc;
  logic signed [CMD_BITS-1:0]   cmd_full;
  logic signed [STEER_BITS-1:0] steer_next;
  logic                         clamped_next;

  always_comb begin
    pk_term    = $signed({1'b0, kp_q8}) * s1_err;
    pd_term    = $signed({1'b0, kd_rate_q8}) * s1_diff;
    pi_term    = $signed({1'b0, ki_dt_q20}) * s1_sum;
    acc_sum    = (ACC_BITS'(pk_term) <<< lfps_pkg::GAIN_SHIFT)
               + ACC_BITS'(pi_term)
               + (ACC_BITS'(pd_term) <<< lfps_pkg::GAIN_SHIFT);
    acc_biased = acc_sum + (acc_sum[ACC_BITS-1] ? ACC_BITS'({Q_BITS{1'b1}}) : ACC_BITS'(0));
    acc_trunc  = acc_biased[ACC_BITS-1:Q_BITS];
    cmd_full   = -acc_trunc;
    if (acc_trunc < LIMIT_NEG) begin
      steer_next   = STEER_BITS'(LIMIT_POS);
      clamped_next = 1'b1;
    end else if (acc_trunc > LIMIT_POS) begin
      steer_next   = STEER_BITS'(LIMIT_NEG);
      clamped_next = 1'b1;
    end else begin
      steer_next   = cmd_full[STEER_BITS-1:0];
      clamped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_valid <= 1'b0;
    end else if (out_ready) begin
      steer_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid) begin
      steer_command <= steer_next;
      clamped       <= clamped_next;
    end
  end

endmodule

FILE: rtl/lfps_checker.sv
// Port-level checks for the line-follow PID steering block, bound to its top level.
module lfps_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   sample_valid,
  input logic                                   sample_stall,
  input logic                                   steer_valid,
  input logic                                   steer_stall,
  input logic signed [lfps_pkg::STEER_BITS-1:0] steer_command,
  input logic                                   clamped
);

  localparam logic signed [lfps_pkg::STEER_BITS-1:0] LIM_POS =
    lfps_pkg::STEER_BITS'(lfps_pkg::STEER_LIMIT);
  localparam logic signed [lfps_pkg::STEER_BITS-1:0] LIM_NEG = -LIM_POS;

  // A delivered command never leaves the steering range.
  assert property (@(posedge clk) disable iff (rst)
    steer_valid |-> (steer_command <= LIM_POS && steer_command >= LIM_NEG))
    else $error("steer_command outside the steering range");

  // The clamp flag only rides on a command sitting at one of the limits.
  assert property (@(posedge clk) disable iff (rst)
    (steer_valid && clamped) |-> (steer_command == LIM_POS || steer_command == LIM_NEG))
    else $error("clamped set on a command inside the range");

  // The input stalls only when every stage is full, so a result must be waiting.
  assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> steer_valid)
    else $error("input stalled with no result waiting");

  // Reset empties the output register.
  assert property (@(posedge clk)
    rst |=> !steer_valid)
    else $error("result still offered after reset");

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    (steer_valid && steer_stall) |=>
      (steer_valid && $stable(steer_command) && $stable(clamped)))
    else $error("stalled result changed or vanished");

endmodule

bind line_follow_pid_steering lfps_checker u_lfps_checker (.*);
